// ===== src/ffpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared constants and codes of the first-fit partition allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

	localparam int MAX_SEGMENTS_DEF = 16;
	localparam int MEM_UNITS_DEF    = 128;
	localparam int NUM_DRIVES_DEF   = 4;
	localparam int TOTAL_SIZE_RST   = 100;

	// request types
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_FIT    = 3'd1;
	localparam logic [2:0] ST_NO_DRIVES = 3'd2;
	localparam logic [2:0] ST_TBL_FULL  = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;

endpackage

// ===== src/first_fit_partition_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_partition_allocator_top
// First-fit memory partition allocator with coalescing, plus a tape drive pool.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; one result comes
// back later on done for exactly one cycle, and the receiver cannot stall it.
// The segment table lives in a single-port-write, registered-read memory and
// is walked one entry at a time (address, then data). An allocate scans the
// table; on a split it moves each later entry up one place and then writes
// the two halves. A free scans, fetches the next neighbor if there is one,
// writes the merged entry and moves later entries down over absorbed ones.
// The table walk sets how long a request takes. After reset the block holds
// busy high in S_INIT while it writes the initial free segment.
// A configuration transfer (only while busy is low) reloads the table with one
// free segment of the new size; drive state is kept.
// ----------------------------------------------------------------------------
module first_fit_partition_allocator_top
	import ffpa_pkg::*;
#(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
	parameter int MEM_UNITS    = MEM_UNITS_DEF,
	parameter int NUM_DRIVES   = NUM_DRIVES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// request
	input  logic       start,
	output logic       busy,
	input  logic       req_type,
	input  logic [7:0] mem_size,
	input  logic [2:0] drive_count,
	input  logic [6:0] start_addr,
	input  logic [3:0] drive_mask,
	// result
	output logic       done,
	output logic [2:0] status,
	output logic [6:0] granted_start,
	output logic [3:0] granted_drives,
	// configuration
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	// widths
	localparam int LW   = $clog2(MEM_UNITS + 1);        // segment length
	localparam int EW   = LW + 1;                       // entry: {busy, len}
	localparam int CW   = (LW > 8) ? LW : 8;            // compare width
	localparam int IW   = $clog2(MAX_SEGMENTS);         // memory address
	localparam int NW   = $clog2(MAX_SEGMENTS + 1);     // count / walk index
	localparam int DCW  = $clog2(NUM_DRIVES + 1);
	localparam int DXW  = (DCW > 3) ? DCW : 3;
	// memory size after reset, kept within MEM_UNITS
	localparam int RST_LEN = (TOTAL_SIZE_RST > MEM_UNITS) ? MEM_UNITS : TOTAL_SIZE_RST;

	// sequencer states
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_SCAN_RD = 4'd1;
	localparam logic [3:0] S_SCAN_EV = 4'd2;
	localparam logic [3:0] S_NEXT_RD = 4'd3;
	localparam logic [3:0] S_NEXT_EV = 4'd4;
	localparam logic [3:0] S_MERGE   = 4'd5;
	localparam logic [3:0] S_UP_RD   = 4'd6;
	localparam logic [3:0] S_UP_WR   = 4'd7;
	localparam logic [3:0] S_SPLIT_A = 4'd8;
	localparam logic [3:0] S_SPLIT_B = 4'd9;
	localparam logic [3:0] S_DN_RD   = 4'd10;
	localparam logic [3:0] S_DN_WR   = 4'd11;
	localparam logic [3:0] S_INIT    = 4'd12;

	logic [3:0] state_q;

	// segment table memory; starts are rebuilt by summing lengths on the walk
	logic [EW-1:0] seg_mem [MAX_SEGMENTS];
	logic [EW-1:0] rdata_q;
	logic [IW-1:0] raddr;
	logic          we;
	logic [IW-1:0] waddr;
	logic [EW-1:0] wdata;

	// latched request
	logic          req_q;
	logic [7:0]    size_q;
	logic [2:0]    need_q;
	logic [6:0]    addr_q;
	logic [3:0]    mask_q;

	// walk state
	logic [NW-1:0] count_q;
	logic [NW-1:0] idx_q;
	logic [NW-1:0] sh_q;
	logic [NW-1:0] src_q;
	logic [NW-1:0] dst_q;
	logic [1:0]    rm_n_q;
	logic [LW-1:0] start_acc_q;
	logic [LW-1:0] prev_len_q;
	logic          prev_busy_q;
	logic [LW-1:0] cur_len_q;
	logic [LW-1:0] next_len_q;
	logic          next_free_q;
	logic [NUM_DRIVES-1:0] drives_busy_q;

	// result registers
	logic          done_q;
	logic [2:0]    status_q;
	logic [6:0]    gstart_q;
	logic [3:0]    gdrv_q;

	// entry under evaluation
	logic          e_busy;
	logic [LW-1:0] e_len;
	assign e_busy = rdata_q[LW];
	assign e_len  = rdata_q[LW-1:0];

	// drive pool: free count and lowest free drives
	logic [DCW-1:0]        free_cnt;
	logic [NUM_DRIVES-1:0] grant;
	logic [NUM_DRIVES-1:0] release_m;
	logic [NUM_DRIVES+3:0] mask_ext;
	logic [NUM_DRIVES+3:0] grant_ext;

	always_comb begin
		logic [DXW-1:0] taken;
		taken    = '0;
		grant    = '0;
		free_cnt = '0;
		for (int d = 0; d < NUM_DRIVES; d++) begin
			if (!drives_busy_q[d]) begin
				free_cnt = free_cnt + DCW'(1);
				if (taken < DXW'(need_q)) begin
					grant[d] = 1'b1;
					taken    = taken + DXW'(1);
				end
			end
		end
	end

	assign mask_ext  = {{NUM_DRIVES{1'b0}}, mask_q};
	assign release_m = mask_ext[NUM_DRIVES-1:0];
	assign grant_ext = {4'b0, grant};

	// configuration clamp: 0 -> 1, above MEM_UNITS -> MEM_UNITS
	logic [CW-1:0] cfg_ext;
	logic [LW-1:0] cfg_len;
	always_comb begin
		cfg_ext = CW'(cfg_data);
		if (cfg_ext == '0)
			cfg_len = LW'(1);
		else if (cfg_ext > CW'(MEM_UNITS))
			cfg_len = LW'(MEM_UNITS);
		else
			cfg_len = cfg_ext[LW-1:0];
	end

	logic cfg_fire;
	assign cfg_ready = (state_q == S_IDLE);
	assign cfg_fire  = cfg_valid && cfg_ready;

	// fit and match tests on the entry just read
	logic fit;
	logic exact;
	logic hit;
	assign fit   = !e_busy && (CW'(e_len) >= CW'(size_q));
	assign exact = (CW'(e_len) == CW'(size_q));
	assign hit   = e_busy && (start_acc_q == LW'(addr_q));

	// merge arithmetic
	logic          merge_prev;
	logic [LW-1:0] merged_len;
	assign merge_prev = (idx_q != '0) && !prev_busy_q;
	always_comb begin
		merged_len = cur_len_q + (next_free_q ? next_len_q : '0);
		if (merge_prev)
			merged_len = merged_len + prev_len_q;
	end

	// read address
	always_comb begin
		case (state_q)
			S_NEXT_RD: raddr = IW'(idx_q + NW'(1));
			S_UP_RD:   raddr = sh_q[IW-1:0];
			S_DN_RD:   raddr = src_q[IW-1:0];
			default:   raddr = idx_q[IW-1:0];
		endcase
	end

	// write port
	always_comb begin
		we    = 1'b0;
		waddr = idx_q[IW-1:0];
		wdata = rdata_q;
		case (state_q)
			S_INIT: begin
				// one free segment covering the reset memory size
				we    = 1'b1;
				waddr = '0;
				wdata = {1'b0, LW'(RST_LEN)};
			end
			S_IDLE: begin
				if (cfg_fire) begin
					we    = 1'b1;
					waddr = '0;
					wdata = {1'b0, cfg_len};
				end
			end
			S_SCAN_EV: begin
				// whole-segment grant marks the entry busy in place
				if (req_q == REQ_ALLOC && fit && exact &&
				    DXW'(free_cnt) >= DXW'(need_q)) begin
					we    = 1'b1;
					wdata = {1'b1, e_len};
				end
			end
			S_MERGE: begin
				we    = 1'b1;
				waddr = merge_prev ? IW'(idx_q - NW'(1)) : idx_q[IW-1:0];
				wdata = {1'b0, merged_len};
			end
			S_UP_WR: begin
				we    = 1'b1;
				waddr = IW'(sh_q + NW'(1));
			end
			S_SPLIT_A: begin
				we    = 1'b1;
				waddr = IW'(idx_q + NW'(1));
				wdata = {1'b0, cur_len_q - LW'(size_q)};
			end
			S_SPLIT_B: begin
				we    = 1'b1;
				wdata = {1'b1, LW'(size_q)};
			end
			S_DN_WR: begin
				we    = 1'b1;
				waddr = dst_q[IW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			seg_mem[waddr] <= wdata;
		rdata_q <= seg_mem[raddr];
	end

	// request latch (payload, no reset)
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q  <= req_type;
			size_q <= mem_size;
			need_q <= drive_count;
			addr_q <= start_addr;
			mask_q <= drive_mask;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_INIT;
			count_q       <= NW'(1);
			drives_busy_q <= '0;
			done_q        <= 1'b0;
			idx_q         <= '0;
			sh_q          <= '0;
			src_q         <= '0;
			dst_q         <= '0;
			rm_n_q        <= '0;
			start_acc_q   <= '0;
			prev_len_q    <= '0;
			prev_busy_q   <= 1'b0;
			cur_len_q     <= '0;
			next_len_q    <= '0;
			next_free_q   <= 1'b0;
			status_q      <= ST_OK;
			gstart_q      <= '0;
			gdrv_q        <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_INIT: state_q <= S_IDLE;
				S_IDLE: begin
					if (cfg_fire)
						count_q <= NW'(1);
					if (start) begin
						idx_q       <= '0;
						start_acc_q <= '0;
						prev_busy_q <= 1'b1;
						if (req_type == REQ_ALLOC && mem_size == '0) begin
							done_q   <= 1'b1;
							status_q <= ST_NO_FIT;
							gstart_q <= '0;
							gdrv_q   <= '0;
						end else begin
							state_q <= S_SCAN_RD;
						end
					end
				end
				S_SCAN_RD: begin
					if (idx_q == count_q) begin
						// walked off the end of the table
						done_q   <= 1'b1;
						gstart_q <= '0;
						gdrv_q   <= '0;
						state_q  <= S_IDLE;
						if (req_q == REQ_ALLOC) begin
							status_q <= ST_NO_FIT;
						end else begin
							status_q      <= ST_NOT_FOUND;
							drives_busy_q <= drives_busy_q & ~release_m;
						end
					end else begin
						state_q <= S_SCAN_EV;
					end
				end
				S_SCAN_EV: begin
					if (req_q == REQ_ALLOC && fit) begin
						cur_len_q <= e_len;
						gstart_q  <= '0;
						gdrv_q    <= '0;
						if (DXW'(free_cnt) < DXW'(need_q)) begin
							done_q   <= 1'b1;
							status_q <= ST_NO_DRIVES;
							state_q  <= S_IDLE;
						end else if (exact) begin
							done_q        <= 1'b1;
							status_q      <= ST_OK;
							gstart_q      <= start_acc_q[6:0];
							gdrv_q        <= grant_ext[3:0];
							drives_busy_q <= drives_busy_q | grant;
							state_q       <= S_IDLE;
						end else if (count_q == NW'(MAX_SEGMENTS)) begin
							done_q   <= 1'b1;
							status_q <= ST_TBL_FULL;
							state_q  <= S_IDLE;
						end else begin
							sh_q    <= count_q - NW'(1);
							state_q <= S_UP_RD;
						end
					end else if (req_q == REQ_FREE && hit) begin
						cur_len_q   <= e_len;
						next_free_q <= 1'b0;
						if (idx_q + NW'(1) < count_q)
							state_q <= S_NEXT_RD;
						else
							state_q <= S_MERGE;
					end else begin
						start_acc_q <= start_acc_q + e_len;
						prev_len_q  <= e_len;
						prev_busy_q <= e_busy;
						idx_q       <= idx_q + NW'(1);
						state_q     <= S_SCAN_RD;
					end
				end
				S_NEXT_RD: state_q <= S_NEXT_EV;
				S_NEXT_EV: begin
					next_len_q  <= e_len;
					next_free_q <= !e_busy;
					state_q     <= S_MERGE;
				end
				S_MERGE: begin
					// close the gap left by absorbed entries
					if (merge_prev) begin
						dst_q  <= idx_q;
						src_q  <= idx_q + (next_free_q ? NW'(2) : NW'(1));
						rm_n_q <= next_free_q ? 2'd2 : 2'd1;
						state_q <= S_DN_RD;
					end else if (next_free_q) begin
						dst_q  <= idx_q + NW'(1);
						src_q  <= idx_q + NW'(2);
						rm_n_q <= 2'd1;
						state_q <= S_DN_RD;
					end else begin
						done_q        <= 1'b1;
						status_q      <= ST_OK;
						gstart_q      <= '0;
						gdrv_q        <= '0;
						drives_busy_q <= drives_busy_q & ~release_m;
						state_q       <= S_IDLE;
					end
				end
				S_DN_RD: begin
					if (src_q >= count_q) begin
						count_q       <= count_q - NW'(rm_n_q);
						done_q        <= 1'b1;
						status_q      <= ST_OK;
						gstart_q      <= '0;
						gdrv_q        <= '0;
						drives_busy_q <= drives_busy_q & ~release_m;
						state_q       <= S_IDLE;
					end else begin
						state_q <= S_DN_WR;
					end
				end
				S_DN_WR: begin
					src_q   <= src_q + NW'(1);
					dst_q   <= dst_q + NW'(1);
					state_q <= S_DN_RD;
				end
				S_UP_RD: begin
					if (sh_q == idx_q)
						state_q <= S_SPLIT_A;
					else
						state_q <= S_UP_WR;
				end
				S_UP_WR: begin
					sh_q    <= sh_q - NW'(1);
					state_q <= S_UP_RD;
				end
				S_SPLIT_A: state_q <= S_SPLIT_B;
				S_SPLIT_B: begin
					count_q       <= count_q + NW'(1);
					done_q        <= 1'b1;
					status_q      <= ST_OK;
					gstart_q      <= start_acc_q[6:0];
					gdrv_q        <= grant_ext[3:0];
					drives_busy_q <= drives_busy_q | grant;
					state_q       <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign done           = done_q;
	assign status         = status_q;
	assign granted_start  = gstart_q;
	assign granted_drives = gdrv_q;

endmodule

// ===== src/ffpa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_checker
// Port-level checks of the allocator top level, attached by bind.
// ----------------------------------------------------------------------------
module ffpa_checker
	import ffpa_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [2:0] status,
	input logic [6:0] granted_start,
	input logic [3:0] granted_drives,
	input logic       cfg_ready
);

	// accepted request makes the block busy, or raises done for a zero-size allocate
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("request transfer did not start work");

	// a result only shows once the block is idle again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while busy");

	// status stays within the defined codes
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status <= ST_NOT_FOUND)
		else $error("status code out of range");

	// failed results carry no grant
	a_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> granted_start == '0 && granted_drives == '0)
		else $error("grant on a failed request");

	// config only while idle
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> !busy)
		else $error("config ready while busy");

endmodule

bind first_fit_partition_allocator_top ffpa_checker u_ffpa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.status        (status),
	.granted_start (granted_start),
	.granted_drives(granted_drives),
	.cfg_ready     (cfg_ready)
);
